[sv/mac_keyed_slot_table_core_defines.svh]
// Assertion macros shared by the core's checking code.
`ifndef MAC_KEYED_SLOT_TABLE_CORE_DEFINES_SVH
`define MAC_KEYED_SLOT_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MKST_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mkst check failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define MKST_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mkst check failed: next-cycle implication");

`endif

[sv/mkst_pkg.sv]
package mkst_pkg;

    localparam int ADDR_W       = 48;
    localparam int TIME_W       = 32;
    localparam int SLOT_FIELD_W = 3;
    localparam int OUTCOME_W    = 2;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_HIT   = 2'd0,
        OUTCOME_CLAIM = 2'd1,
        OUTCOME_EVICT = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [TIME_W-1:0] now_ms;
    } detection_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        outcome_t                outcome;
    } result_t;

endpackage

[sv/mkst_oldest.sv]
module mkst_oldest #(
    parameter int SLOTS = 8
) (
    input  logic [SLOTS-1:0][mkst_pkg::TIME_W-1:0] times,
    output logic [$clog2(SLOTS)-1:0]               oldest
);

    localparam int IDXW   = $clog2(SLOTS);
    localparam int LEAVES = 1 << IDXW;
    localparam int NODES  = 2 * LEAVES - 1;

    logic [mkst_pkg::TIME_W-1:0] node_time [NODES];
    logic [IDXW-1:0]             node_idx  [NODES];

    // Pad unused leaves with the largest time; ties keep the left (lower) side.
    for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
        if (l < SLOTS) begin : g_real
            assign node_time[LEAVES-1+l] = times[l];
        end
        else begin : g_pad
            assign node_time[LEAVES-1+l] = '1;
        end
        assign node_idx[LEAVES-1+l] = IDXW'(l);
    end

    for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
        logic left_wins;

        assign left_wins    = node_time[2*n+1] <= node_time[2*n+2];
        assign node_time[n] = left_wins ? node_time[2*n+1] : node_time[2*n+2];
        assign node_idx[n]  = left_wins ? node_idx[2*n+1]  : node_idx[2*n+2];
    end

    assign oldest = node_idx[0];

endmodule

[sv/mkst_table.sv]
module mkst_table #(
    parameter int SLOTS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mkst_pkg::detection_t   item,
    input  logic                   update,
    output mkst_pkg::result_t      choice
);

    localparam int IDXW = $clog2(SLOTS);

    logic [SLOTS-1:0]                        used_reg;
    logic [SLOTS-1:0]                        used_next;
    logic [SLOTS-1:0][mkst_pkg::ADDR_W-1:0]  addr_reg;
    logic [SLOTS-1:0][mkst_pkg::ADDR_W-1:0]  addr_next;
    logic [SLOTS-1:0][mkst_pkg::TIME_W-1:0]  time_reg;
    logic [SLOTS-1:0][mkst_pkg::TIME_W-1:0]  time_next;

    logic [SLOTS-1:0]  match;
    logic              hit;
    logic [IDXW-1:0]   hit_idx;
    logic              free;
    logic [IDXW-1:0]   free_idx;
    logic [IDXW-1:0]   victim_idx;
    logic [IDXW-1:0]   idx;
    mkst_pkg::outcome_t outcome;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i] = used_reg[i] && (addr_reg[i] == item.address);
        end
    end

    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit     = 1'b1;
                hit_idx = IDXW'(i);
            end
            if (!used_reg[i])
            begin
                free     = 1'b1;
                free_idx = IDXW'(i);
            end
        end
    end

    mkst_oldest #(
        .SLOTS (SLOTS)
    ) u_oldest (
        .times  (time_reg),
        .oldest (victim_idx)
    );

    always_comb
    begin
        priority if (hit)
        begin
            idx     = hit_idx;
            outcome = mkst_pkg::OUTCOME_HIT;
        end
        else if (free)
        begin
            idx     = free_idx;
            outcome = mkst_pkg::OUTCOME_CLAIM;
        end
        else
        begin
            idx     = victim_idx;
            outcome = mkst_pkg::OUTCOME_EVICT;
        end
    end

    assign choice.slot    = mkst_pkg::SLOT_FIELD_W'(idx);
    assign choice.outcome = outcome;

    always_comb
    begin
        used_next = used_reg;
        addr_next = addr_reg;
        time_next = time_reg;
        if (update)
        begin
            used_next[idx] = 1'b1;
            addr_next[idx] = item.address;
            time_next[idx] = item.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        time_reg <= time_next;
    end

endmodule

[sv/mac_keyed_slot_table_core.sv]
// Channel     Direction  Handshake                         Payload
// detection   in         detection_valid / detection_stall  mkst_pkg::detection_t
// result      out        result_valid / result_stall        mkst_pkg::result_t
//
// One transaction per cycle in, one per cycle out while result is not stalled;
// each passes the input register, then the result register. Lookup,
// free-slot search and oldest-slot tree sit between the input register and
// the result register; the table updates at the same edge. Reset clears all
// used marks at once; no clearing pass. A stalled result holds a valid input register, which then stalls detection.

`include "mac_keyed_slot_table_core_defines.svh"

module mac_keyed_slot_table_core #(
    parameter int SLOTS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  detection_valid,
    output logic                  detection_stall,
    input  mkst_pkg::detection_t  detection,
    output logic                  result_valid,
    input  logic                  result_stall,
    output mkst_pkg::result_t     result
);

    logic                  item_valid_reg;
    logic                  item_valid_next;
    mkst_pkg::detection_t  item_reg;
    mkst_pkg::detection_t  item_next;
    logic                  result_valid_reg;
    logic                  result_valid_next;
    mkst_pkg::result_t     result_reg;
    mkst_pkg::result_t     result_next;

    logic                  advance;
    mkst_pkg::result_t     choice;

    assign advance         = !result_valid_reg || !result_stall;
    assign detection_stall = item_valid_reg && !advance;

    mkst_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_reg),
        .update (item_valid_reg && advance),
        .choice (choice)
    );

    always_comb
    begin
        item_valid_next   = item_valid_reg;
        item_next         = item_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (!detection_stall)
        begin
            item_valid_next = detection_valid;
            if (detection_valid)
            begin
                item_next = detection;
            end
        end
        if (advance)
        begin
            result_valid_next = item_valid_reg;
            if (item_valid_reg)
            begin
                result_next = choice;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `MKST_ASSERT_NOW(a_stall_when_blocked, clk, rst_n, item_valid_reg && result_valid_reg && result_stall, detection_stall)
    `MKST_ASSERT_NEXT(a_item_reaches_result, clk, rst_n, item_valid_reg && advance, result_valid_reg)
    `MKST_ASSERT_NEXT(a_result_drains, clk, rst_n, result_valid_reg && !result_stall && !item_valid_reg, !result_valid_reg)

endmodule
